### sv/cpd_pkg.sv
package cpd_pkg;

    localparam int unsigned CountWidth = 17;

    localparam logic [CountWidth-1:0] HdrBytes = 17'd10;
    localparam logic [CountWidth-1:0] CrcBytes = 17'd4;
    localparam logic [CountWidth-1:0] CountMax = 17'h1FFFF;
    localparam logic [31:0] CrcPoly = 32'h82F63B78;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    // Header byte offsets.
    localparam logic [CountWidth-1:0] PosSyncLo = 17'd0;
    localparam logic [CountWidth-1:0] PosSyncHi = 17'd1;
    localparam logic [CountWidth-1:0] PosVersion = 17'd2;
    localparam logic [CountWidth-1:0] PosId = 17'd3;
    localparam logic [CountWidth-1:0] PosLenLo = 17'd4;
    localparam logic [CountWidth-1:0] PosLenHi = 17'd5;
    localparam logic [CountWidth-1:0] PosSeq0 = 17'd6;
    localparam logic [CountWidth-1:0] PosSeq1 = 17'd7;
    localparam logic [CountWidth-1:0] PosSeq2 = 17'd8;
    localparam logic [CountWidth-1:0] PosSeq3 = 17'd9;

    localparam logic KindPayload = 1'b0;
    localparam logic KindSummary = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INCOMPLETE  = 3'd1,
        ST_BAD_SYNC    = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_BAD_CRC     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_SYNC_WORD        = 2'd0,
        CFG_PROTOCOL_VERSION = 2'd1,
        CFG_MAX_PAYLOAD      = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_item;

    typedef struct packed {
        logic             kind;
        logic [7:0]       payload_byte;
        t_status          frame_status;
        logic [7:0]       message_id;
        logic [15:0]      payload_length;
        logic [31:0]      sequence_number;
        logic [CountWidth-1:0] frame_bytes;
    } t_result;

    typedef struct packed {
        logic [15:0] sync_word;
        logic [7:0]  protocol_version;
        logic [15:0] max_payload;
    } t_cfg;

    // Reflected CRC-32C update over one byte, unrolled to an XOR network.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/cpd_channels.sv
interface cpd_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source(output valid, output data_byte, output end_of_buffer, input ready);
    modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface cpd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic [31:0] sequence_number;
    logic [16:0] frame_bytes;

    modport source(output valid, output kind, output payload_byte, output frame_status,
                   output message_id, output payload_length, output sequence_number,
                   output frame_bytes, input ready);
    modport sink(input valid, input kind, input payload_byte, input frame_status,
                 input message_id, input payload_length, input sequence_number,
                 input frame_bytes, output ready);
endinterface

interface cpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### sv/cpd_cfg_regs.sv
module cpd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpd_cfg_if.sink       i_cfg,
    output cpd_pkg::t_cfg o_cfg
);

    cpd_pkg::t_cfg r_cfg;
    cpd_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            // An index beyond the register list is dropped.
            unique case (cpd_pkg::t_cfg_index'(i_cfg.index))
                cpd_pkg::CFG_SYNC_WORD:        n_cfg.sync_word = i_cfg.data;
                cpd_pkg::CFG_PROTOCOL_VERSION: n_cfg.protocol_version = i_cfg.data[7:0];
                cpd_pkg::CFG_MAX_PAYLOAD:      n_cfg.max_payload = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word        <= 16'd0;
            r_cfg.protocol_version <= 8'd0;
            r_cfg.max_payload      <= 16'hFFFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### sv/cpd_in_reg.sv
module cpd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cpd_item_if.sink       i_item,
    input  logic           i_take,
    output logic           o_valid,
    output cpd_pkg::t_item o_item
);

    logic           r_valid;
    cpd_pkg::t_item r_item;
    logic           load;

    assign i_item.ready = !r_valid || i_take;
    assign load = i_item.valid && i_item.ready;
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.data_byte     <= i_item.data_byte;
            r_item.end_of_buffer <= i_item.end_of_buffer;
        end
    end

endmodule

### sv/cpd_frame_core.sv
module cpd_frame_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpd_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  cpd_pkg::t_item   i_item,
    input  logic             i_res_space,
    output logic             o_take,
    output logic             o_res_valid,
    output cpd_pkg::t_result o_res
);

    localparam int unsigned Cw = cpd_pkg::CountWidth;

    logic [Cw-1:0]    r_count;
    logic [15:0]      r_sync;
    logic [7:0]       r_version;
    logic [7:0]       r_id;
    logic [15:0]      r_length;
    logic [31:0]      r_seq;
    logic [31:0]      r_crc;
    logic [31:0]      r_rx_crc;
    cpd_pkg::t_status r_hdr_err;

    logic [Cw-1:0]    n_count;
    logic [15:0]      n_sync;
    logic [7:0]       n_version;
    logic [7:0]       n_id;
    logic [15:0]      n_length;
    logic [31:0]      n_seq;
    logic [31:0]      n_crc;
    logic [31:0]      n_rx_crc;
    cpd_pkg::t_status n_hdr_err;

    logic [7:0]       b;
    logic [Cw-1:0]    pos;
    logic [Cw-1:0]    body_end;
    logic [Cw-1:0]    required;
    logic [Cw-1:0]    crc_off;
    logic             is_payload;
    cpd_pkg::t_status status;

    assign b   = i_item.data_byte;
    assign pos = r_count;
    assign o_take = i_valid && i_res_space;

    always_comb begin
        n_count   = (pos == cpd_pkg::CountMax) ? pos : pos + 17'd1;
        n_sync    = r_sync;
        n_version = r_version;
        n_id      = r_id;
        n_length  = r_length;
        n_seq     = r_seq;
        n_crc     = r_crc;
        n_rx_crc  = r_rx_crc;
        n_hdr_err = r_hdr_err;

        unique case (pos)
            cpd_pkg::PosSyncLo:  n_sync[7:0]    = b;
            cpd_pkg::PosSyncHi:  n_sync[15:8]   = b;
            cpd_pkg::PosVersion: n_version      = b;
            cpd_pkg::PosId:      n_id           = b;
            cpd_pkg::PosLenLo:   n_length[7:0]  = b;
            cpd_pkg::PosLenHi:   n_length[15:8] = b;
            cpd_pkg::PosSeq0:    n_seq[7:0]     = b;
            cpd_pkg::PosSeq1:    n_seq[15:8]    = b;
            cpd_pkg::PosSeq2:    n_seq[23:16]   = b;
            cpd_pkg::PosSeq3:    n_seq[31:24]   = b;
            default: ;
        endcase

        // The header check runs when the last header byte arrives, with the
        // register values of that moment.
        if (pos == cpd_pkg::PosSeq3) begin
            priority if (n_sync != i_cfg.sync_word) begin
                n_hdr_err = cpd_pkg::ST_BAD_SYNC;
            end else if (n_version != i_cfg.protocol_version) begin
                n_hdr_err = cpd_pkg::ST_BAD_VERSION;
            end else if (n_length > i_cfg.max_payload) begin
                n_hdr_err = cpd_pkg::ST_BAD_LENGTH;
            end else begin
                n_hdr_err = cpd_pkg::ST_OK;
            end
        end

        // While the header is still arriving the length may be partial, but
        // the body end can never fall below the header size.
        body_end = cpd_pkg::HdrBytes + {1'b0, n_length};
        required = body_end + cpd_pkg::CrcBytes;
        crc_off  = pos - body_end;
        is_payload = (pos >= cpd_pkg::HdrBytes) && (pos < body_end);

        if (pos < body_end) begin
            n_crc = cpd_pkg::crc32c_byte(r_crc, b);
        end else if (pos < required) begin
            unique case (crc_off[1:0])
                2'd0: n_rx_crc[7:0]   = r_rx_crc[7:0]   | b;
                2'd1: n_rx_crc[15:8]  = r_rx_crc[15:8]  | b;
                2'd2: n_rx_crc[23:16] = r_rx_crc[23:16] | b;
                2'd3: n_rx_crc[31:24] = r_rx_crc[31:24] | b;
            endcase
        end

        priority if (n_count < cpd_pkg::HdrBytes) begin
            status = cpd_pkg::ST_INCOMPLETE;
        end else if (n_hdr_err != cpd_pkg::ST_OK) begin
            status = n_hdr_err;
        end else if (n_count < required) begin
            status = cpd_pkg::ST_INCOMPLETE;
        end else if (n_count != required) begin
            status = cpd_pkg::ST_BAD_LENGTH;
        end else if ((n_crc ^ cpd_pkg::CrcInit) != n_rx_crc) begin
            status = cpd_pkg::ST_BAD_CRC;
        end else begin
            status = cpd_pkg::ST_OK;
        end

        o_res.kind            = cpd_pkg::KindPayload;
        o_res.payload_byte    = 8'd0;
        o_res.frame_status    = cpd_pkg::ST_OK;
        o_res.message_id      = n_id;
        o_res.payload_length  = n_length;
        o_res.sequence_number = n_seq;
        o_res.frame_bytes     = '0;
        o_res_valid           = 1'b0;

        if (i_item.end_of_buffer) begin
            o_res.kind         = cpd_pkg::KindSummary;
            o_res.frame_status = status;
            if (n_count < cpd_pkg::HdrBytes) begin
                o_res.message_id      = 8'd0;
                o_res.payload_length  = 16'd0;
                o_res.sequence_number = 32'd0;
            end
            if (status == cpd_pkg::ST_OK) begin
                o_res.frame_bytes = required;
            end
            o_res_valid = o_take;
        end else begin
            o_res.payload_byte = b;
            o_res_valid = o_take && is_payload && (n_hdr_err == cpd_pkg::ST_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.end_of_buffer)) begin
            r_count   <= '0;
            r_sync    <= 16'd0;
            r_version <= 8'd0;
            r_id      <= 8'd0;
            r_length  <= 16'd0;
            r_seq     <= 32'd0;
            r_crc     <= cpd_pkg::CrcInit;
            r_rx_crc  <= 32'd0;
            r_hdr_err <= cpd_pkg::ST_OK;
        end else if (o_take) begin
            r_count   <= n_count;
            r_sync    <= n_sync;
            r_version <= n_version;
            r_id      <= n_id;
            r_length  <= n_length;
            r_seq     <= n_seq;
            r_crc     <= n_crc;
            r_rx_crc  <= n_rx_crc;
            r_hdr_err <= n_hdr_err;
        end
    end

endmodule

### sv/cpd_out_reg.sv
module cpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cpd_pkg::t_result i_res,
    output logic             o_space,
    cpd_result_if.source     o_result
);

    logic             r_valid;
    cpd_pkg::t_result r_res;

    assign o_space = !r_valid || o_result.ready;

    assign o_result.valid           = r_valid;
    assign o_result.kind            = r_res.kind;
    assign o_result.payload_byte    = r_res.payload_byte;
    assign o_result.frame_status    = r_res.frame_status;
    assign o_result.message_id      = r_res.message_id;
    assign o_result.payload_length  = r_res.payload_length;
    assign o_result.sequence_number = r_res.sequence_number;
    assign o_result.frame_bytes     = r_res.frame_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### sv/crc32c_packet_deframer_unit.sv
// CRC-32C packet deframer. Bytes of a received buffer enter on i_item, the last
// one marked by end_of_buffer; the block checks a ten-byte little-endian header
// against the sync, version and maximum length registers, passes payload bytes
// out one per result once the header is good, and ends every buffer with one
// summary result carrying the status and the header fields. It takes one byte
// in every clock cycle when the result side keeps up. A byte is held in the
// input register after it is accepted; its result is loaded into the result
// register, where it is offered, once that register has space, and until then
// the byte stays in the input register. The one-byte CRC update network
// between those two registers sets the clock period. Bytes that make no
// result still wait for that space before they are taken. The configuration
// port is always ready and takes a write in every cycle.
module crc32c_packet_deframer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpd_item_if.sink      i_item,
    cpd_cfg_if.sink       i_cfg,
    cpd_result_if.source  o_result
);

    cpd_pkg::t_cfg    cfg;
    cpd_pkg::t_item   item;
    cpd_pkg::t_result res;
    logic             item_valid;
    logic             take;
    logic             res_valid;
    logic             res_space;

    cpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    cpd_frame_core u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_res_space (res_space),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .o_space  (res_space),
        .o_result (o_result)
    );

endmodule

### tb/sv/crc32c_packet_deframer_unit_tb.sv
`timescale 1ns / 1ps

module crc32c_packet_deframer_unit_tb;

    localparam int unsigned SettleCycles = 6;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned MaxReports = 100;
    localparam logic [1:0] CfgUnknownIndex = 2'd3;

    logic clk;
    logic rst_n;

    cpd_item_if   item_if ();
    cpd_cfg_if    cfg_if ();
    cpd_result_if res_if ();

    crc32c_packet_deframer_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Register values as the block should hold them.
    logic [15:0] reg_sync_word;
    logic [7:0]  reg_version;
    logic [15:0] reg_max_payload;

    // Frame state of the deframer prediction.
    logic [cpd_pkg::CountWidth-1:0] rx_count;
    logic [15:0] cap_sync;
    logic [7:0]  cap_version;
    logic [7:0]  cap_id;
    logic [15:0] cap_length;
    logic [31:0] cap_sequence;
    logic [31:0] crc_acc;
    logic [31:0] rx_crc;
    cpd_pkg::t_status hdr_status;

    cpd_pkg::t_item   byte_queue[$];
    cpd_pkg::t_result expected_records[$];
    int unsigned queued_count;
    int unsigned accepted_count;
    int unsigned mismatch_count;
    int unsigned idle_pct;
    logic hold_request;
    logic holding;

    function automatic logic [31:0] crc32c_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        logic fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r = (r >> 1) ^ (fb ? cpd_pkg::CrcPoly : 32'h0);
        end
        return r;
    endfunction

    function automatic void clear_frame();
        rx_count = '0;
        cap_sync = '0;
        cap_version = '0;
        cap_id = '0;
        cap_length = '0;
        cap_sequence = '0;
        crc_acc = cpd_pkg::CrcInit;
        rx_crc = '0;
        hdr_status = cpd_pkg::ST_OK;
    endfunction

    // Advances the frame state by one accepted byte and queues what it produces.
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        logic [cpd_pkg::CountWidth-1:0] pos;
        int unsigned pos_n;
        int unsigned count_n;
        int unsigned body_end;
        int unsigned required;
        logic is_payload;
        cpd_pkg::t_status st;
        cpd_pkg::t_result rec;
        pos = rx_count;
        pos_n = pos;
        count_n = (pos < cpd_pkg::CountMax) ? pos_n + 1 : pos_n;
        rx_count = count_n[cpd_pkg::CountWidth-1:0];

        case (pos)
            cpd_pkg::PosSyncLo:  cap_sync = {8'h00, b};
            cpd_pkg::PosSyncHi:  cap_sync[15:8] = b;
            cpd_pkg::PosVersion: cap_version = b;
            cpd_pkg::PosId:      cap_id = b;
            cpd_pkg::PosLenLo:   cap_length = {8'h00, b};
            cpd_pkg::PosLenHi:   cap_length[15:8] = b;
            cpd_pkg::PosSeq0:    cap_sequence = {24'h0, b};
            cpd_pkg::PosSeq1:    cap_sequence[15:8] = b;
            cpd_pkg::PosSeq2:    cap_sequence[23:16] = b;
            cpd_pkg::PosSeq3:    cap_sequence[31:24] = b;
            default: ;
        endcase

        // The header check uses the registers as they stand at the last header byte.
        if (pos == cpd_pkg::PosSeq3) begin
            if (cap_sync != reg_sync_word) begin
                hdr_status = cpd_pkg::ST_BAD_SYNC;
            end else if (cap_version != reg_version) begin
                hdr_status = cpd_pkg::ST_BAD_VERSION;
            end else if (cap_length > reg_max_payload) begin
                hdr_status = cpd_pkg::ST_BAD_LENGTH;
            end else begin
                hdr_status = cpd_pkg::ST_OK;
            end
        end

        body_end = int'(cpd_pkg::HdrBytes) + cap_length;
        is_payload = 1'b0;
        if (pos_n < cpd_pkg::HdrBytes) begin
            crc_acc = crc32c_next(crc_acc, b);
        end else if (pos_n < body_end) begin
            crc_acc = crc32c_next(crc_acc, b);
            is_payload = 1'b1;
        end else if (pos_n < body_end + cpd_pkg::CrcBytes) begin
            rx_crc = rx_crc | (32'(b) << (8 * (pos_n - body_end)));
        end

        rec = '0;
        if (last) begin
            required = body_end + cpd_pkg::CrcBytes;
            if (count_n < cpd_pkg::HdrBytes) begin
                st = cpd_pkg::ST_INCOMPLETE;
            end else if (hdr_status != cpd_pkg::ST_OK) begin
                st = hdr_status;
            end else if (count_n < required) begin
                st = cpd_pkg::ST_INCOMPLETE;
            end else if (count_n != required) begin
                st = cpd_pkg::ST_BAD_LENGTH;
            end else if (~crc_acc != rx_crc) begin
                st = cpd_pkg::ST_BAD_CRC;
            end else begin
                st = cpd_pkg::ST_OK;
            end
            rec.kind = cpd_pkg::KindSummary;
            rec.frame_status = st;
            if (count_n >= cpd_pkg::HdrBytes) begin
                rec.message_id = cap_id;
                rec.payload_length = cap_length;
                rec.sequence_number = cap_sequence;
            end
            rec.frame_bytes = (st == cpd_pkg::ST_OK) ?
                              required[cpd_pkg::CountWidth-1:0] : '0;
            expected_records.push_back(rec);
            clear_frame();
        end else if (is_payload && hdr_status == cpd_pkg::ST_OK) begin
            rec.kind = cpd_pkg::KindPayload;
            rec.payload_byte = b;
            rec.frame_status = cpd_pkg::ST_OK;
            rec.message_id = cap_id;
            rec.payload_length = cap_length;
            rec.sequence_number = cap_sequence;
            expected_records.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_record();
        cpd_pkg::t_result want;
        if (expected_records.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
        end else begin
            want = expected_records.pop_front();
            compare_field("kind", res_if.kind, want.kind);
            compare_field("payload_byte", res_if.payload_byte, want.payload_byte);
            compare_field("frame_status", res_if.frame_status, want.frame_status);
            compare_field("message_id", res_if.message_id, want.message_id);
            compare_field("payload_length", res_if.payload_length, want.payload_length);
            compare_field("sequence_number", res_if.sequence_number, want.sequence_number);
            compare_field("frame_bytes", res_if.frame_bytes, want.frame_bytes);
        end
    endtask

    // Byte driver: holds a request until it is taken, with random gaps between.
    int unsigned gap_left;
    always @(posedge clk) begin : drive_bytes
        cpd_pkg::t_item nxt;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                accepted_count++;
                deframe_byte(item_if.data_byte, item_if.end_of_buffer);
            end
            if (item_if.valid && !item_if.ready) begin
                item_if.valid <= 1'b1;
            end else if (gap_left != 0) begin
                item_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_queue.size() != 0 && idle_pct != 0
                         && $urandom_range(99) < idle_pct) begin
                item_if.valid <= 1'b0;
                gap_left <= $urandom_range(3);
            end else if (byte_queue.size() != 0) begin
                nxt = byte_queue.pop_front();
                item_if.valid <= 1'b1;
                item_if.data_byte <= nxt.data_byte;
                item_if.end_of_buffer <= nxt.end_of_buffer;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls.
    int unsigned stall_left;
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_record();
            end
            if (holding) begin
                res_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                res_if.ready <= 1'b0;
                stall_left <= $urandom_range(3);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // One long hold on the result side so the block backs up into its input.
    initial begin
        holding = 1'b0;
        wait (hold_request);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holding <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            cpd_pkg::CFG_SYNC_WORD:        reg_sync_word = value;
            cpd_pkg::CFG_PROTOCOL_VERSION: reg_version = value[7:0];
            cpd_pkg::CFG_MAX_PAYLOAD:      reg_max_payload = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] sync, input logic [7:0] ver,
                             input logic [15:0] max_len, input bit poke_unknown);
        write_reg(cpd_pkg::CFG_SYNC_WORD, sync);
        write_reg(cpd_pkg::CFG_PROTOCOL_VERSION, {8'h00, ver});
        write_reg(cpd_pkg::CFG_MAX_PAYLOAD, max_len);
        if (poke_unknown) begin
            write_reg(CfgUnknownIndex, 16'($urandom()));
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_records.size() != 0) begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Builds one buffer of `total` bytes: header, payload and CRC as far as they
    // reach, then filler bytes past the frame.
    task automatic queue_buffer(input logic [15:0] sync, input logic [7:0] ver,
                                input logic [15:0] len, input int unsigned total,
                                input bit corrupt_crc);
        logic [7:0] bytes_q[$];
        logic [31:0] seq;
        logic [31:0] crc;
        cpd_pkg::t_item it;
        seq = $urandom();
        bytes_q.push_back(sync[7:0]);
        bytes_q.push_back(sync[15:8]);
        bytes_q.push_back(ver);
        bytes_q.push_back(8'($urandom()));
        bytes_q.push_back(len[7:0]);
        bytes_q.push_back(len[15:8]);
        for (int k = 0; k < 4; k++) begin
            bytes_q.push_back(seq[8*k +: 8]);
        end
        while (bytes_q.size() < int'(cpd_pkg::HdrBytes) + len && bytes_q.size() < total) begin
            bytes_q.push_back(8'($urandom()));
        end
        if (bytes_q.size() == int'(cpd_pkg::HdrBytes) + len && bytes_q.size() < total) begin
            crc = cpd_pkg::CrcInit;
            foreach (bytes_q[k]) begin
                crc = crc32c_next(crc, bytes_q[k]);
            end
            crc = ~crc;
            if (corrupt_crc) begin
                crc = crc ^ (32'h1 << $urandom_range(31));
            end
            for (int k = 0; k < 4; k++) begin
                bytes_q.push_back(crc[8*k +: 8]);
            end
        end
        while (bytes_q.size() < total) begin
            bytes_q.push_back(8'($urandom()));
        end
        for (int unsigned k = 0; k < total; k++) begin
            it.data_byte = bytes_q[k];
            it.end_of_buffer = (k == total - 1);
            byte_queue.push_back(it);
            queued_count++;
        end
    endtask

    // Mostly well-formed frames with random content; the rest are damaged.
    task automatic queue_random_buffer();
        int unsigned pick;
        int unsigned len_cap;
        int unsigned len;
        int unsigned frame_len;
        int unsigned total;
        logic [15:0] sync;
        logic [7:0] ver;
        bit corrupt;
        pick = $urandom_range(99);
        sync = reg_sync_word;
        ver = reg_version;
        len_cap = (reg_max_payload < 24) ? reg_max_payload : 24;
        len = $urandom_range(len_cap, 0);
        corrupt = 1'b0;
        frame_len = cpd_pkg::HdrBytes + len + cpd_pkg::CrcBytes;
        total = frame_len;
        if (pick < 55) begin
            total = frame_len;
        end else if (pick < 65) begin
            corrupt = 1'b1;
        end else if (pick < 73) begin
            total = $urandom_range(frame_len - 1, cpd_pkg::HdrBytes);
        end else if (pick < 80) begin
            total = frame_len + $urandom_range(6, 1);
        end else if (pick < 85) begin
            sync = reg_sync_word ^ 16'($urandom_range(16'hFFFF, 1));
            if ($urandom_range(1)) begin
                ver = reg_version ^ 8'($urandom_range(8'hFF, 1));
            end
            total = $urandom_range(frame_len + 3, cpd_pkg::HdrBytes);
        end else if (pick < 90) begin
            ver = reg_version ^ 8'($urandom_range(8'hFF, 1));
            total = $urandom_range(frame_len + 3, cpd_pkg::HdrBytes);
        end else if (pick < 95) begin
            if (reg_max_payload != 16'hFFFF) begin
                len = $urandom_range(16'hFFFF, reg_max_payload + 1);
                total = $urandom_range(30, cpd_pkg::HdrBytes);
            end
        end else begin
            total = $urandom_range(cpd_pkg::HdrBytes - 1, 1);
        end
        queue_buffer(sync, ver, 16'(len), total, corrupt);
    endtask

    task automatic queue_random_bytes(input int unsigned count);
        int unsigned target;
        target = queued_count + count;
        while (queued_count < target) begin
            queue_random_buffer();
        end
    endtask

    initial begin
        cpd_pkg::t_item one;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.data_byte = '0;
        item_if.end_of_buffer = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = cpd_pkg::CFG_SYNC_WORD;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        hold_request = 1'b0;
        queued_count = 0;
        accepted_count = 0;
        mismatch_count = 0;
        idle_pct = 20;
        reg_sync_word = '0;
        reg_version = '0;
        reg_max_payload = 16'hFFFF;
        clear_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: a one-byte buffer, a good empty
        // frame and a header with the wrong sync.
        one.data_byte = 8'hFF;
        one.end_of_buffer = 1'b1;
        byte_queue.push_back(one);
        queued_count++;
        queue_buffer(16'h0000, 8'h00, 16'h0000, 14, 1'b0);
        queue_buffer(16'hFFFF, 8'h00, 16'h0000, 10, 1'b0);
        wait_idle();
        queue_random_bytes(80);
        wait_idle();

        idle_pct = 25;
        configure(16'hFFFF, 8'hFF, 16'h0000, 1'b1);
        queue_random_bytes(100);
        wait_idle();

        idle_pct = 15;
        configure(16'($urandom()), 8'($urandom()), 16'($urandom_range(30, 1)), 1'b0);
        queue_random_bytes(100);
        hold_request = 1'b1;
        wait_idle();

        idle_pct = 35;
        configure(16'($urandom()), 8'($urandom()), 16'd8, 1'b0);
        queue_random_bytes(100);
        wait_idle();

        // A longer legal frame, then a buffer that runs well past its frame.
        idle_pct = 0;
        configure(16'($urandom()), 8'($urandom()), 16'hFFFF, 1'b0);
        queue_buffer(reg_sync_word, reg_version, 16'd40, 54, 1'b0);
        queue_buffer(reg_sync_word, reg_version, 16'd3, 30, 1'b0);
        wait_idle();

        configure(16'($urandom()), 8'($urandom()), 16'($urandom_range(40, 10)), 1'b1);
        queue_random_bytes(100);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
sv/cpd_pkg.sv
sv/cpd_channels.sv
sv/cpd_cfg_regs.sv
sv/cpd_in_reg.sv
sv/cpd_frame_core.sv
sv/cpd_out_reg.sv
sv/crc32c_packet_deframer_unit.sv
tb/sv/crc32c_packet_deframer_unit_tb.sv
